/* rtl/core/scpmq_pkg.sv */
// ----------------------------------------------------------------------------
// Shared chunk pool multi-queue package
// Sizes, status codes and small helper functions of the shared chunk pool.
// ----------------------------------------------------------------------------
package scpmq_pkg;

    // Pool geometry.
    localparam int CHUNK_WORDS = 16;
    localparam int NUM_CHUNKS  = 8;
    localparam int NUM_QUEUES  = 4;
    localparam int DATA_WIDTH  = 32;

    // Fixed widths of the request and result fields.
    localparam int QID_IN_W  = 2;
    localparam int WORD_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_O_W = 4;

    // Derived internal widths.
    localparam int QID_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int CID_W  = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int CNT_W  = $clog2(NUM_CHUNKS + 1);
    localparam int OFF_W  = $clog2(CHUNK_WORDS + 1);
    localparam int DEPTH  = NUM_CHUNKS * CHUNK_WORDS;
    localparam int ADDR_W = $clog2(DEPTH);

    // Request types.
    localparam logic REQ_ENQUEUE = 1'b0;
    localparam logic REQ_DEQUEUE = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Folds the request's queue field onto the queues that exist.
    function automatic logic [QID_W-1:0] fold_queue_id(input logic [QID_IN_W-1:0] id);
        int v;
        v = int'(id);
        for (int i = 0; i < (1 << QID_IN_W); i++) begin
            if (v >= NUM_QUEUES) begin
                v = v - NUM_QUEUES;
            end
        end
        return QID_W'(v);
    endfunction

    // Next position of a free list pointer.
    function automatic logic [CID_W-1:0] wrap_inc(input logic [CID_W-1:0] ptr);
        logic [CID_W-1:0] res;
        if (ptr == CID_W'(NUM_CHUNKS - 1)) begin
            res = '0;
        end else begin
            res = ptr + CID_W'(1);
        end
        return res;
    endfunction

    // Word address of an offset within a chunk.
    function automatic logic [ADDR_W-1:0] word_addr(input logic [CID_W-1:0] cid,
                                                    input logic [OFF_W-1:0] off);
        return ADDR_W'(cid) * ADDR_W'(CHUNK_WORDS) + ADDR_W'(off);
    endfunction

endpackage

/* rtl/core/shared_chunk_pool_multi_queue.sv */
// ----------------------------------------------------------------------------
// Shared chunk pool multi-queue
// Several FIFO queues that share one word store cut into fixed-size chunks.
// ----------------------------------------------------------------------------

// A user of this block sends one enqueue or dequeue request per cycle while
// s_ready is high and gets exactly one result per request, in request order;
// each request passes through the request register and then the result
// register. The sustained rate is one request per cycle while the result side
// takes every result: the request register feeds the descriptor and free list
// update logic, and the data store, a single-port memory with a registered
// read, is written or read as the result register loads. The data
// store, the chunk links and the head and tail chunk ids are never cleared;
// the sequencing of the block never reads one of their entries before it has
// been written, so the block is ready right after reset with no clearing pass.
// The free list starts out holding chunk ids zero upward in order. A rejected
// request (enqueue to a full queue, dequeue from an empty one) changes
// nothing and reports its reason in the status field.
module shared_chunk_pool_multi_queue (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_req_type,
    input  logic [scpmq_pkg::QID_IN_W-1:0]       s_queue_id,
    input  logic signed [scpmq_pkg::WORD_W-1:0]  s_write_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [scpmq_pkg::WORD_W-1:0]  m_read_value,
    output logic [scpmq_pkg::STATUS_W-1:0]       m_status,
    output logic                                 m_queue_full,
    output logic                                 m_queue_empty,
    output logic [scpmq_pkg::COUNT_O_W-1:0]      m_used_chunks,
    output logic [scpmq_pkg::COUNT_O_W-1:0]      m_free_chunks
);

    // Request register.
    logic                                 req_valid_reg;
    logic                                 req_type_reg;
    logic [scpmq_pkg::QID_W-1:0]          req_q_reg;
    logic [scpmq_pkg::WORD_W-1:0]         req_wdata_reg;

    // Per-queue descriptors.
    logic [scpmq_pkg::CID_W-1:0] head_reg [scpmq_pkg::NUM_QUEUES];
    logic [scpmq_pkg::CID_W-1:0] tail_reg [scpmq_pkg::NUM_QUEUES];
    logic [scpmq_pkg::OFF_W-1:0] rd_off_reg [scpmq_pkg::NUM_QUEUES];
    logic [scpmq_pkg::OFF_W-1:0] wr_off_reg [scpmq_pkg::NUM_QUEUES];
    logic [scpmq_pkg::CNT_W-1:0] cnt_reg [scpmq_pkg::NUM_QUEUES];

    // Chunk links and the free list of chunk ids.
    logic [scpmq_pkg::CID_W-1:0] link_reg [scpmq_pkg::NUM_CHUNKS];
    logic [scpmq_pkg::CID_W-1:0] free_fifo_reg [scpmq_pkg::NUM_CHUNKS];
    logic [scpmq_pkg::CID_W-1:0] free_rd_ptr_reg;
    logic [scpmq_pkg::CID_W-1:0] free_wr_ptr_reg;
    logic [scpmq_pkg::CNT_W-1:0] free_count_reg;

    // Word store.
    logic [scpmq_pkg::DATA_WIDTH-1:0] data_mem [scpmq_pkg::DEPTH];
    logic [scpmq_pkg::DATA_WIDTH-1:0] rdata_reg;

    // Result register.
    logic                              out_valid_reg;
    scpmq_pkg::status_t                out_status_reg;
    logic                              out_full_reg;
    logic                              out_empty_reg;
    logic [scpmq_pkg::CNT_W-1:0]       out_used_reg;
    logic [scpmq_pkg::CNT_W-1:0]       out_free_reg;
    logic                              out_rd_ok_reg;

    // Update logic of the request in the request register.
    logic                              adv;
    logic [scpmq_pkg::CID_W-1:0]       cur_head, cur_tail, new_cid;
    logic [scpmq_pkg::OFF_W-1:0]       cur_ro, cur_wo, ro_inc;
    logic [scpmq_pkg::CNT_W-1:0]       cur_cnt;
    logic                              full_now, used_up;
    logic                              take, give, link_we, mem_we;
    logic [scpmq_pkg::ADDR_W-1:0]      mem_addr;
    logic [scpmq_pkg::CID_W-1:0]       head_next, tail_next;
    logic [scpmq_pkg::OFF_W-1:0]       ro_next, wo_next;
    logic [scpmq_pkg::CNT_W-1:0]       cnt_next;
    logic [scpmq_pkg::CID_W-1:0]       free_rd_ptr_next, free_wr_ptr_next;
    logic [scpmq_pkg::CNT_W-1:0]       free_count_next;
    scpmq_pkg::status_t                status_next;
    logic                              rd_ok_next;
    logic                              full_next;

    // The request register moves on whenever the result register is free or
    // its result is being taken in this cycle.
    assign adv     = req_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !req_valid_reg || adv;

    always_comb begin
        cur_head = head_reg[req_q_reg];
        cur_tail = tail_reg[req_q_reg];
        cur_ro   = rd_off_reg[req_q_reg];
        cur_wo   = wr_off_reg[req_q_reg];
        cur_cnt  = cnt_reg[req_q_reg];
        new_cid  = free_fifo_reg[free_rd_ptr_reg];
        ro_inc   = cur_ro + scpmq_pkg::OFF_W'(1);

        head_next        = cur_head;
        tail_next        = cur_tail;
        ro_next          = cur_ro;
        wo_next          = cur_wo;
        cnt_next         = cur_cnt;
        free_rd_ptr_next = free_rd_ptr_reg;
        free_wr_ptr_next = free_wr_ptr_reg;
        free_count_next  = free_count_reg;
        take             = 1'b0;
        give             = 1'b0;
        link_we          = 1'b0;
        mem_we           = 1'b0;
        used_up          = 1'b0;
        mem_addr         = '0;
        status_next      = scpmq_pkg::STATUS_DONE;
        rd_ok_next       = 1'b0;

        // A queue is full when it needs a new chunk and none is free.
        if (cur_cnt == '0) begin
            full_now = (free_count_reg == '0);
        end else begin
            full_now = (cur_wo >= scpmq_pkg::OFF_W'(scpmq_pkg::CHUNK_WORDS))
                       && (free_count_reg == '0);
        end

        case (req_type_reg)
            scpmq_pkg::REQ_ENQUEUE: begin
                if (full_now) begin
                    status_next = scpmq_pkg::STATUS_FULL;
                end else begin
                    if (cur_cnt == '0) begin
                        take      = 1'b1;
                        head_next = new_cid;
                        tail_next = new_cid;
                        ro_next   = '0;
                        wo_next   = '0;
                        cnt_next  = scpmq_pkg::CNT_W'(1);
                    end else if (cur_wo >= scpmq_pkg::OFF_W'(scpmq_pkg::CHUNK_WORDS)) begin
                        take      = 1'b1;
                        link_we   = 1'b1;
                        tail_next = new_cid;
                        wo_next   = '0;
                        cnt_next  = cur_cnt + scpmq_pkg::CNT_W'(1);
                    end
                    mem_we   = 1'b1;
                    mem_addr = scpmq_pkg::word_addr(tail_next, wo_next);
                    wo_next  = wo_next + scpmq_pkg::OFF_W'(1);
                end
            end
            scpmq_pkg::REQ_DEQUEUE: begin
                if (cur_cnt == '0) begin
                    status_next = scpmq_pkg::STATUS_EMPTY;
                end else begin
                    rd_ok_next = 1'b1;
                    mem_addr   = scpmq_pkg::word_addr(cur_head, cur_ro);
                    ro_next    = ro_inc;
                    // The last chunk is used up once reads catch up with
                    // writes; any other chunk once all its words are read.
                    if (cur_cnt == scpmq_pkg::CNT_W'(1)) begin
                        used_up = (ro_inc >= cur_wo);
                    end else begin
                        used_up = (ro_inc >= scpmq_pkg::OFF_W'(scpmq_pkg::CHUNK_WORDS));
                    end
                    if (used_up) begin
                        give     = 1'b1;
                        cnt_next = cur_cnt - scpmq_pkg::CNT_W'(1);
                        ro_next  = '0;
                        if (cnt_next != '0) begin
                            head_next = link_reg[cur_head];
                        end else begin
                            wo_next = '0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        if (take) begin
            free_rd_ptr_next = scpmq_pkg::wrap_inc(free_rd_ptr_reg);
            free_count_next  = free_count_reg - scpmq_pkg::CNT_W'(1);
        end
        if (give) begin
            free_wr_ptr_next = scpmq_pkg::wrap_inc(free_wr_ptr_reg);
            free_count_next  = free_count_reg + scpmq_pkg::CNT_W'(1);
        end

        if (cnt_next == '0) begin
            full_next = (free_count_next == '0);
        end else begin
            full_next = (wo_next >= scpmq_pkg::OFF_W'(scpmq_pkg::CHUNK_WORDS))
                        && (free_count_next == '0);
        end
    end

    // Control state: handshakes, descriptor offsets and counts, and the free list.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            free_rd_ptr_reg <= '0;
            free_wr_ptr_reg <= '0;
            free_count_reg  <= scpmq_pkg::CNT_W'(scpmq_pkg::NUM_CHUNKS);
            for (int i = 0; i < scpmq_pkg::NUM_CHUNKS; i++) begin
                free_fifo_reg[i] <= scpmq_pkg::CID_W'(i);
            end
            for (int i = 0; i < scpmq_pkg::NUM_QUEUES; i++) begin
                rd_off_reg[i] <= '0;
                wr_off_reg[i] <= '0;
                cnt_reg[i]    <= '0;
            end
        end else begin
            if (s_ready) begin
                req_valid_reg <= s_valid;
            end
            if (adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (adv) begin
                rd_off_reg[req_q_reg] <= ro_next;
                wr_off_reg[req_q_reg] <= wo_next;
                cnt_reg[req_q_reg]    <= cnt_next;
                free_rd_ptr_reg       <= free_rd_ptr_next;
                free_wr_ptr_reg       <= free_wr_ptr_next;
                free_count_reg        <= free_count_next;
                if (give) begin
                    free_fifo_reg[free_wr_ptr_reg] <= cur_head;
                end
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_type_reg  <= s_req_type;
            req_q_reg     <= scpmq_pkg::fold_queue_id(s_queue_id);
            req_wdata_reg <= s_write_value;
        end
        if (adv) begin
            head_reg[req_q_reg] <= head_next;
            tail_reg[req_q_reg] <= tail_next;
            if (link_we) begin
                link_reg[cur_tail] <= new_cid;
            end
            out_status_reg <= status_next;
            out_full_reg   <= full_next;
            out_empty_reg  <= (cnt_next == '0);
            out_used_reg   <= cnt_next;
            out_free_reg   <= free_count_next;
            out_rd_ok_reg  <= rd_ok_next;
        end
    end

    // Word store: one address per cycle while the request register advances,
    // written on an enqueue and read into rdata_reg on a dequeue.
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (mem_we) begin
                data_mem[mem_addr] <= scpmq_pkg::DATA_WIDTH'($unsigned(req_wdata_reg));
            end
            if (rd_ok_next) begin
                rdata_reg <= data_mem[mem_addr];
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_read_value  = out_rd_ok_reg ? signed'(scpmq_pkg::WORD_W'(rdata_reg))
                                         : '0;
    assign m_status      = out_status_reg;
    assign m_queue_full  = out_full_reg;
    assign m_queue_empty = out_empty_reg;
    assign m_used_chunks = scpmq_pkg::COUNT_O_W'(out_used_reg);
    assign m_free_chunks = scpmq_pkg::COUNT_O_W'(out_free_reg);

    // Every chunk is either on the free list or held by exactly one queue.
    int chk_total;
    always_comb begin
        chk_total = int'(free_count_reg);
        for (int i = 0; i < scpmq_pkg::NUM_QUEUES; i++) begin
            chk_total = chk_total + int'(cnt_reg[i]);
        end
    end

    a_chunks_conserved: assert property (@(posedge aclk) disable iff (!aresetn)
        chk_total == scpmq_pkg::NUM_CHUNKS)
        else $error("chunk accounting lost or duplicated a chunk");

    a_empty_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_status_reg == scpmq_pkg::STATUS_EMPTY)
        |-> out_empty_reg && (out_used_reg == '0))
        else $error("dequeue rejected while the queue holds chunks");

    a_full_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_status_reg == scpmq_pkg::STATUS_FULL)
        |-> out_full_reg && (out_free_reg == '0))
        else $error("enqueue rejected while a chunk was available");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_empty_reg == (out_used_reg == '0)))
        else $error("empty flag disagrees with the chunk count");

    a_request_held: assert property (@(posedge aclk) disable iff (!aresetn)
        req_valid_reg && !adv |=> req_valid_reg && $stable(req_q_reg))
        else $error("stalled request left the request register");

endmodule

/* dv/scpmq_result_checker.sv */
// ----------------------------------------------------------------------------
// Shared chunk pool multi-queue result checker
// Watches both channels, predicts each result of the queue manager, and
// compares the results that arrive, in order, field by field.
// ----------------------------------------------------------------------------
module scpmq_result_checker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic                                  s_req_type,
    input  logic [scpmq_pkg::QID_IN_W-1:0]        s_queue_id,
    input  logic signed [scpmq_pkg::WORD_W-1:0]   s_write_value,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic signed [scpmq_pkg::WORD_W-1:0]   m_read_value,
    input  logic [scpmq_pkg::STATUS_W-1:0]        m_status,
    input  logic                                  m_queue_full,
    input  logic                                  m_queue_empty,
    input  logic [scpmq_pkg::COUNT_O_W-1:0]       m_used_chunks,
    input  logic [scpmq_pkg::COUNT_O_W-1:0]       m_free_chunks,
    output int                                    fail_count,
    output int                                    pending_results
);

    // Room for expected results; the block never holds more than a few.
    localparam int EXP_DEPTH = 8;

    typedef struct {
        logic signed [scpmq_pkg::WORD_W-1:0] read_value;
        logic [scpmq_pkg::STATUS_W-1:0]      status;
        logic                                queue_full;
        logic                                queue_empty;
        logic [scpmq_pkg::COUNT_O_W-1:0]     used_chunks;
        logic [scpmq_pkg::COUNT_O_W-1:0]     pool_free;
    } pool_result_t;

    // Shadow copy of the pool.
    logic [scpmq_pkg::DATA_WIDTH-1:0] word_mem   [scpmq_pkg::DEPTH];
    logic [scpmq_pkg::CID_W-1:0]      chunk_link [scpmq_pkg::NUM_CHUNKS];
    logic [scpmq_pkg::CID_W-1:0]      free_ids   [scpmq_pkg::NUM_CHUNKS];
    logic [scpmq_pkg::CID_W-1:0]      free_rd;
    logic [scpmq_pkg::CID_W-1:0]      free_wr;
    logic [scpmq_pkg::CNT_W-1:0]      free_cnt;
    logic [scpmq_pkg::CID_W-1:0]      head_chunk [scpmq_pkg::NUM_QUEUES];
    logic [scpmq_pkg::CID_W-1:0]      tail_chunk [scpmq_pkg::NUM_QUEUES];
    logic [scpmq_pkg::OFF_W-1:0]      rd_off     [scpmq_pkg::NUM_QUEUES];
    logic [scpmq_pkg::OFF_W-1:0]      wr_off     [scpmq_pkg::NUM_QUEUES];
    logic [scpmq_pkg::CNT_W-1:0]      chunk_cnt  [scpmq_pkg::NUM_QUEUES];

    // Expected results in request order, kept in a small ring.
    pool_result_t expected_buf [EXP_DEPTH];
    int           exp_wr_idx;
    int           exp_rd_idx;
    int           exp_count;

    function automatic logic queue_cannot_grow(input int q);
        if (chunk_cnt[q] == 0) begin
            return free_cnt == 0;
        end
        return (wr_off[q] >= scpmq_pkg::CHUNK_WORDS) && (free_cnt == 0);
    endfunction

    // Applies one request to the shadow pool and returns the result it yields.
    function automatic pool_result_t apply_queue_request(
        input logic                           req_type,
        input logic [scpmq_pkg::QID_IN_W-1:0] qid,
        input logic [scpmq_pkg::WORD_W-1:0]   wval);
        pool_result_t                r;
        int                          q;
        logic [scpmq_pkg::CID_W-1:0] c;
        logic                        used_up;
        q = int'(qid) % scpmq_pkg::NUM_QUEUES;
        r.read_value = '0;
        r.status     = scpmq_pkg::STATUS_DONE;
        if (req_type == scpmq_pkg::REQ_ENQUEUE) begin
            if (queue_cannot_grow(q)) begin
                r.status = scpmq_pkg::STATUS_FULL;
            end else begin
                if (chunk_cnt[q] == 0 || wr_off[q] >= scpmq_pkg::CHUNK_WORDS) begin
                    c        = free_ids[free_rd];
                    free_rd  = scpmq_pkg::CID_W'((int'(free_rd) + 1) % scpmq_pkg::NUM_CHUNKS);
                    free_cnt = free_cnt - 1'b1;
                    if (chunk_cnt[q] == 0) begin
                        head_chunk[q] = c;
                        rd_off[q]     = '0;
                    end else begin
                        chunk_link[tail_chunk[q]] = c;
                    end
                    tail_chunk[q] = c;
                    wr_off[q]     = '0;
                    chunk_cnt[q]  = chunk_cnt[q] + 1'b1;
                end
                word_mem[int'(tail_chunk[q]) * scpmq_pkg::CHUNK_WORDS + int'(wr_off[q])] =
                    scpmq_pkg::DATA_WIDTH'(wval);
                wr_off[q] = wr_off[q] + 1'b1;
            end
        end else if (chunk_cnt[q] == 0) begin
            r.status = scpmq_pkg::STATUS_EMPTY;
        end else begin
            c            = head_chunk[q];
            r.read_value = scpmq_pkg::WORD_W'(
                word_mem[int'(c) * scpmq_pkg::CHUNK_WORDS + int'(rd_off[q])]);
            rd_off[q]    = rd_off[q] + 1'b1;
            // The last chunk of a queue is used up once reads catch up with writes.
            if (chunk_cnt[q] == 1) begin
                used_up = rd_off[q] >= wr_off[q];
            end else begin
                used_up = rd_off[q] >= scpmq_pkg::CHUNK_WORDS;
            end
            if (used_up) begin
                free_ids[free_wr] = c;
                free_wr           = scpmq_pkg::CID_W'((int'(free_wr) + 1)
                                                      % scpmq_pkg::NUM_CHUNKS);
                free_cnt          = free_cnt + 1'b1;
                chunk_cnt[q]      = chunk_cnt[q] - 1'b1;
                rd_off[q]         = '0;
                if (chunk_cnt[q] != 0) begin
                    head_chunk[q] = chunk_link[c];
                end else begin
                    wr_off[q] = '0;
                end
            end
        end
        r.queue_full  = queue_cannot_grow(q);
        r.queue_empty = chunk_cnt[q] == 0;
        r.used_chunks = scpmq_pkg::COUNT_O_W'(chunk_cnt[q]);
        r.pool_free   = scpmq_pkg::COUNT_O_W'(free_cnt);
        return r;
    endfunction

    task automatic report_field(input string field, input logic signed [63:0] expected_v,
                                input logic signed [63:0] actual_v);
        if (actual_v !== expected_v) begin
            $error("%s: expected %0d, got %0d", field, expected_v, actual_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        pool_result_t exp_r;
        if (!aresetn) begin
            for (int i = 0; i < scpmq_pkg::NUM_CHUNKS; i++) begin
                free_ids[i] = scpmq_pkg::CID_W'(i);
            end
            for (int q = 0; q < scpmq_pkg::NUM_QUEUES; q++) begin
                rd_off[q]    = '0;
                wr_off[q]    = '0;
                chunk_cnt[q] = '0;
            end
            free_rd    = '0;
            free_wr    = '0;
            free_cnt   = scpmq_pkg::CNT_W'(scpmq_pkg::NUM_CHUNKS);
            exp_wr_idx = 0;
            exp_rd_idx = 0;
            exp_count  = 0;
        end else begin
            // A request is booked before a result is taken, so even a result
            // in the same cycle would find its expectation.
            if (s_valid && s_ready) begin
                if (exp_count == EXP_DEPTH) begin
                    $error("more requests outstanding than the block can hold");
                    fail_count++;
                end else begin
                    expected_buf[exp_wr_idx] =
                        apply_queue_request(s_req_type, s_queue_id, s_write_value);
                    exp_wr_idx = (exp_wr_idx + 1) % EXP_DEPTH;
                    exp_count++;
                end
            end
            if (m_valid && m_ready) begin
                if (exp_count == 0) begin
                    $error("result arrived with no request outstanding");
                    fail_count++;
                end else begin
                    exp_r      = expected_buf[exp_rd_idx];
                    exp_rd_idx = (exp_rd_idx + 1) % EXP_DEPTH;
                    exp_count--;
                    report_field("m_read_value", exp_r.read_value, m_read_value);
                    report_field("m_status", exp_r.status, m_status);
                    report_field("m_queue_full", exp_r.queue_full, m_queue_full);
                    report_field("m_queue_empty", exp_r.queue_empty, m_queue_empty);
                    report_field("m_used_chunks", exp_r.used_chunks, m_used_chunks);
                    report_field("m_free_chunks", exp_r.pool_free, m_free_chunks);
                end
            end
        end
        pending_results = exp_count;
    end

endmodule

/* dv/shared_chunk_pool_multi_queue_tb.sv */
// ----------------------------------------------------------------------------
// Shared chunk pool multi-queue testbench
// Drives enqueue and dequeue requests into the queue manager under random
// stalls on both channels; a checker beside the block predicts and compares
// every result, and this module reports the verdict.
// ----------------------------------------------------------------------------
module shared_chunk_pool_multi_queue_tb;

    // Number of random requests after the directed ones.
    localparam int RANDOM_REQUESTS = 1850;
    // Random requests in this window run with both sides never idling.
    localparam int STEADY_FIRST = 600;
    localparam int STEADY_LAST  = 900;
    // Idle chance per cycle, in percent, on each side.
    localparam int IDLE_PCT = 22;
    // The cycle limit leaves a wide margin over the length of a correct run.
    localparam int CYCLE_LIMIT = 200000;
    // Cycles to wait after the last result, to catch any extra result.
    localparam int DRAIN_CYCLES = 8;

    // Traffic shapes of a random burst: mostly enqueues to fill the pool,
    // mostly dequeues to drain it, or an even mix.
    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } traffic_mode_t;

    logic                                  aclk;
    logic                                  aresetn;
    logic                                  s_valid;
    logic                                  s_ready;
    logic                                  s_req_type;
    logic [scpmq_pkg::QID_IN_W-1:0]        s_queue_id;
    logic signed [scpmq_pkg::WORD_W-1:0]   s_write_value;
    logic                                  m_valid;
    logic                                  m_ready = 1'b0;
    logic signed [scpmq_pkg::WORD_W-1:0]   m_read_value;
    logic [scpmq_pkg::STATUS_W-1:0]        m_status;
    logic                                  m_queue_full;
    logic                                  m_queue_empty;
    logic [scpmq_pkg::COUNT_O_W-1:0]       m_used_chunks;
    logic [scpmq_pkg::COUNT_O_W-1:0]       m_free_chunks;

    int   fail_count;
    int   pending_results;
    int   cycle_count;
    bit   idle_on;

    shared_chunk_pool_multi_queue u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_queue_id    (s_queue_id),
        .s_write_value (s_write_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_value  (m_read_value),
        .m_status      (m_status),
        .m_queue_full  (m_queue_full),
        .m_queue_empty (m_queue_empty),
        .m_used_chunks (m_used_chunks),
        .m_free_chunks (m_free_chunks)
    );

    scpmq_result_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_queue_id      (s_queue_id),
        .s_write_value   (s_write_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_value    (m_read_value),
        .m_status        (m_status),
        .m_queue_full    (m_queue_full),
        .m_queue_empty   (m_queue_empty),
        .m_used_chunks   (m_used_chunks),
        .m_free_chunks   (m_free_chunks),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // The watchdog ends a run that hangs, for instance on a lost result.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("shared_chunk_pool_multi_queue_tb failed");
            $finish;
        end
    end

    // The result side stalls at random, except in the steady window. It
    // changes on the falling edge, like every other input of the block.
    always @(negedge aclk) begin
        m_ready <= idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end

    // Sends one request. The task is entered on a falling edge and returns on
    // the falling edge after the request was accepted, with valid still high,
    // so that back-to-back requests keep valid up without a glitch. During an
    // idle gap valid is lowered, once per cycle.
    task automatic send_request(input logic req_type,
                                input logic [scpmq_pkg::QID_IN_W-1:0] qid,
                                input logic [scpmq_pkg::WORD_W-1:0] wval);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= req_type;
        s_queue_id    <= qid;
        s_write_value <= wval;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    // Random traffic in bursts. Each burst has a shape and a favored queue, so
    // the pool is filled up to the point where enqueues are turned away,
    // chunks are chained and recycled, and queues are drained to empty and
    // beyond. About one word in ten is an extreme value.
    task automatic run_random_traffic(input int count);
        int            sent;
        int            burst_len;
        int            enq_pct;
        traffic_mode_t mode;
        logic [1:0]    favored;
        logic          req_type;
        logic [1:0]    qid;
        logic [31:0]   wval;
        sent = 0;
        while (sent < count) begin
            burst_len = $urandom_range(10, 160);
            mode      = traffic_mode_t'($urandom_range(2));
            favored   = 2'($urandom_range(3));
            case (mode)
                MODE_FILL: begin
                    enq_pct = 85;
                end
                MODE_DRAIN: begin
                    enq_pct = 15;
                end
                default: begin
                    enq_pct = 50;
                end
            endcase
            for (int i = 0; i < burst_len && sent < count; i++) begin
                idle_on  = !(sent >= STEADY_FIRST && sent < STEADY_LAST);
                req_type = ($urandom_range(99) < enq_pct) ? scpmq_pkg::REQ_ENQUEUE
                                                           : scpmq_pkg::REQ_DEQUEUE;
                qid      = ($urandom_range(99) < 60) ? favored : 2'($urandom_range(3));
                case ($urandom_range(39))
                    0:       wval = 32'h8000_0000;
                    1:       wval = 32'h7fff_ffff;
                    2:       wval = 32'h0000_0000;
                    3:       wval = 32'hffff_ffff;
                    default: wval = $urandom;
                endcase
                send_request(req_type, qid, wval);
                sent++;
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_req_type    = scpmq_pkg::REQ_ENQUEUE;
        s_queue_id    = '0;
        s_write_value = '0;
        idle_on       = 1'b1;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. A dequeue from an empty queue is turned away first.
        send_request(scpmq_pkg::REQ_DEQUEUE, 2'd0, 32'h0);
        // One word into every queue, with the extreme word values, so that
        // each queue takes its first chunk from the free list in order.
        send_request(scpmq_pkg::REQ_ENQUEUE, 2'd0, 32'h8000_0000);
        send_request(scpmq_pkg::REQ_ENQUEUE, 2'd1, 32'h7fff_ffff);
        send_request(scpmq_pkg::REQ_ENQUEUE, 2'd2, 32'h0000_0000);
        send_request(scpmq_pkg::REQ_ENQUEUE, 2'd3, 32'hffff_ffff);
        send_request(scpmq_pkg::REQ_ENQUEUE, 2'd1, 32'h5555_5555);
        send_request(scpmq_pkg::REQ_ENQUEUE, 2'd2, 32'haaaa_aaaa);
        // A front chunk that is also the tail goes back to the free list as
        // soon as reads catch up with writes, although it is far from full.
        send_request(scpmq_pkg::REQ_DEQUEUE, 2'd0, 32'h0);
        send_request(scpmq_pkg::REQ_DEQUEUE, 2'd0, 32'h0);
        send_request(scpmq_pkg::REQ_DEQUEUE, 2'd1, 32'h0);
        send_request(scpmq_pkg::REQ_DEQUEUE, 2'd1, 32'h0);
        // The next chunk handed out is the next one in the free list, not a
        // just-released one.
        send_request(scpmq_pkg::REQ_ENQUEUE, 2'd0, 32'h1234_5678);
        send_request(scpmq_pkg::REQ_DEQUEUE, 2'd2, 32'h0);
        send_request(scpmq_pkg::REQ_DEQUEUE, 2'd2, 32'h0);
        send_request(scpmq_pkg::REQ_DEQUEUE, 2'd3, 32'h0);
        send_request(scpmq_pkg::REQ_DEQUEUE, 2'd3, 32'h0);
        send_request(scpmq_pkg::REQ_DEQUEUE, 2'd0, 32'h0);

        run_random_traffic(RANDOM_REQUESTS);
        s_valid <= 1'b0;

        // Every request gets exactly one result, so the run is complete once
        // nothing is outstanding; a few more cycles catch any extra result.
        wait (pending_results == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("shared_chunk_pool_multi_queue_tb passed");
        end else begin
            $display("shared_chunk_pool_multi_queue_tb failed");
        end
        $finish;
    end

endmodule
